>>> hw/rtl/bmaff_pkg.sv
// Shared types for the bit map allocator: action codes and the command and
// status bundles between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package bmaff_pkg;

  // Request actions as carried on in_action.
  typedef enum logic [2:0] {
    ACT_SET       = 3'd0,
    ACT_CLEAR     = 3'd1,
    ACT_TRY_SET   = 3'd2,
    ACT_TRY_CLEAR = 3'd3,
    ACT_TEST      = 3'd4,
    ACT_FIND      = 3'd5,
    ACT_SET_ALL   = 3'd6,
    ACT_CLEAR_ALL = 3'd7
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a request and point at its first word
    logic fetch;  // read the word under the pointer
    logic run;    // evaluate the fetched word, write back, maybe read next
    logic clear;  // write zeros under the pointer (post-reset sweep)
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finish;    // the current request completes this cycle
    logic clr_last;  // the clearing sweep is at its last word
  } status_t;

endpackage

>>> hw/rtl/bmaff_ctrl.sv
// Controller for the bit map allocator: sequences reset clearing, word
// fetch and the scan loop. Depends on bmaff_pkg.
`timescale 1ns / 1ps

module bmaff_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bmaff_pkg::status_t st,
  output bmaff_pkg::cmd_t    cmd,
  output logic               busy,
  output logic               out_strobe
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_RUN
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   done_r;

  // Commands follow directly from the current state and, for load, from start.
  always_comb begin
    cmd.load  = (state_r == S_IDLE) && start;
    cmd.fetch = (state_r == S_FETCH);
    cmd.run   = (state_r == S_RUN);
    cmd.clear = (state_r == S_CLEAR);
  end

  // State register with busy and the result strobe as registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          if (st.clr_last) begin
            state_r <= S_IDLE;
            busy_r  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_r <= S_FETCH;
            busy_r  <= 1'b1;
          end
        end
        S_FETCH: begin
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (st.finish) begin
            state_r <= S_IDLE;
            busy_r  <= 1'b0;
            done_r  <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy       = busy_r;
  assign out_strobe = done_r;

endmodule

>>> hw/rtl/bmaff_dp.sv
// Datapath for the bit map allocator: the mark word memory, the word
// pointer, the bit and scan logic and the result registers.
// Depends on bmaff_pkg. WORD_BITS must be a power of two.
`timescale 1ns / 1ps

module bmaff_dp #(
  parameter int MAX_BITS  = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_action,
  input  logic [9:0]         in_bit_index,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_active_bits,
  input  bmaff_pkg::cmd_t    cmd,
  output bmaff_pkg::status_t st,
  output logic               out_ok,
  output logic [9:0]         out_found_index,
  output logic               out_range_error
);

  localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int WBL        = $clog2(WORD_BITS);

  // Mark word memory, cleared by a sweep after reset.
  logic [WORD_BITS-1:0] mem [WORD_COUNT];

  logic [10:0]          active_bits_r;
  bmaff_pkg::action_t   op_r;
  logic [9:0]           idx_r;
  logic [AW-1:0]        addr_r;
  logic [AW-1:0]        waddr_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 ok_r;
  logic [9:0]           fidx_r;
  logic                 err_r;

  logic [10:0]          size;
  logic [31:0]          base_i;
  logic [31:0]          size_i;
  logic [31:0]          diff_i;
  logic [WORD_BITS-1:0] live;
  logic [WORD_BITS-1:0] freeb;
  logic [WBL-1:0]       pos;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 was;
  logic                 in_range;
  logic                 last_word;
  logic                 single_in;
  logic                 finish;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wdata;
  logic                 ok_c;
  logic [9:0]           fidx_c;
  logic                 err_c;
  logic                 rd_en;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // Effective size: the configured size capped at the map capacity.
  always_comb begin
    if (32'(active_bits_r) > 32'(MAX_BITS)) begin
      size = 11'(MAX_BITS);
    end else begin
      size = active_bits_r;
    end
  end

  // Bits of the fetched word that lie below the effective size.
  always_comb begin
    base_i = 32'({waddr_r, {WBL{1'b0}}});
    size_i = 32'(size);
    diff_i = size_i - base_i;
    if (size_i <= base_i) begin
      live = '0;
    end else if (diff_i >= 32'(WORD_BITS)) begin
      live = '1;
    end else begin
      live = ~({WORD_BITS{1'b1}} << diff_i[WBL-1:0]);
    end
  end

  // Lowest free live bit of the fetched word.
  always_comb begin
    freeb = ~rdata_r & live;
    pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (freeb[i]) begin
        pos = WBL'(i);
      end
    end
  end

  assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << idx_r[WBL-1:0];
  assign was       = |(rdata_r & bit_mask);
  assign in_range  = {1'b0, idx_r} < size;
  assign last_word = (waddr_r == AW'(WORD_COUNT - 1));
  assign single_in = (in_action <= bmaff_pkg::ACT_TEST);

  // Evaluation of the fetched word for the current action.
  always_comb begin
    finish = 1'b1;
    wr_en  = 1'b0;
    wdata  = rdata_r;
    ok_c   = 1'b1;
    fidx_c = '0;
    err_c  = 1'b0;
    unique case (op_r)
      bmaff_pkg::ACT_SET: begin
        wr_en = in_range;
        wdata = rdata_r | bit_mask;
      end
      bmaff_pkg::ACT_CLEAR: begin
        wr_en = in_range;
        wdata = rdata_r & ~bit_mask;
      end
      bmaff_pkg::ACT_TRY_SET: begin
        wr_en = in_range;
        wdata = rdata_r | bit_mask;
        ok_c  = !was;
      end
      bmaff_pkg::ACT_TRY_CLEAR: begin
        wr_en = in_range;
        wdata = rdata_r & ~bit_mask;
        ok_c  = was;
      end
      bmaff_pkg::ACT_TEST: begin
        ok_c = was;
      end
      bmaff_pkg::ACT_FIND: begin
        finish = (|freeb) || last_word;
        wr_en  = |freeb;
        wdata  = rdata_r | ({{(WORD_BITS-1){1'b0}}, 1'b1} << pos);
        ok_c   = |freeb;
        fidx_c = (|freeb) ? 10'({waddr_r, pos}) : 10'd0;
      end
      bmaff_pkg::ACT_SET_ALL: begin
        finish = last_word;
        wr_en  = 1'b1;
        wdata  = rdata_r | live;
      end
      bmaff_pkg::ACT_CLEAR_ALL: begin
        finish = last_word;
        wr_en  = 1'b1;
        wdata  = rdata_r & ~live;
      end
      default: begin
        finish = 1'b1;
      end
    endcase
    // An out-of-range single-bit action changes nothing and flags an error.
    if ((op_r <= bmaff_pkg::ACT_TEST) && !in_range) begin
      ok_c  = 1'b0;
      err_c = 1'b1;
    end
  end

  assign st.finish   = finish;
  assign st.clr_last = (addr_r == AW'(WORD_COUNT - 1));

  assign rd_en     = cmd.fetch || (cmd.run && !finish);
  assign mem_we    = cmd.clear || (cmd.run && wr_en);
  assign mem_waddr = cmd.clear ? addr_r : waddr_r;
  assign mem_wdata = cmd.clear ? '0 : wdata;

  // Configuration register and word pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bits_r <= 11'd1024;
      addr_r        <= '0;
    end else begin
      if (cfg_we) begin
        active_bits_r <= cfg_active_bits;
      end
      if (cmd.load) begin
        addr_r <= single_in ? AW'(in_bit_index >> WBL) : '0;
      end else if (rd_en || cmd.clear) begin
        addr_r <= addr_r + AW'(1);
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= bmaff_pkg::action_t'(in_action);
      idx_r <= in_bit_index;
    end
  end

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr_r];
      waddr_r <= addr_r;
    end
  end

  // Result registers, loaded as the request completes.
  always_ff @(posedge clk) begin
    if (cmd.run && finish) begin
      ok_r   <= ok_c;
      fidx_r <= fidx_c;
      err_r  <= err_c;
    end
  end

  assign out_ok          = ok_r;
  assign out_found_index = fidx_r;
  assign out_range_error = err_r;

endmodule

>>> hw/rtl/bitmap_allocator_find_first_free.sv
// Bit map allocator with find-first-free claim, top level.
// Depends on bmaff_pkg, bmaff_ctrl and bmaff_dp.
//
// Usage: a request (in_action, in_bit_index) transfers at a rising edge
// where start is high and busy is low. Each request gives one result on
// out_ok, out_found_index and out_range_error, valid for exactly the one
// cycle in which out_strobe is high; the receiver cannot stall it.
// Sequence: the word is fetched in the cycle after the transfer and
// evaluated in the next; for a single-bit action the result registers and
// out_strobe are loaded as that evaluation ends. Find and claim and the
// whole-map actions evaluate one word per cycle from word 0; find stops
// at the first word holding a free bit below the effective size, or at
// the last word. The memory's single read port sets this scan rate.
// busy drops in the strobe cycle, so the next request may transfer then.
// The size register is written through cfg_we / cfg_active_bits; the
// user must do so only while idle, as the block does not enforce it.
// After reset the memory is cleared by a sweep over every word with busy
// high.
`timescale 1ns / 1ps

module bitmap_allocator_find_first_free #(
  parameter int MAX_BITS  = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [9:0]  in_bit_index,
  input  logic        cfg_we,
  input  logic [10:0] cfg_active_bits,
  output logic        out_strobe,
  output logic        out_ok,
  output logic [9:0]  out_found_index,
  output logic        out_range_error
);

  bmaff_pkg::cmd_t    cmd;
  bmaff_pkg::status_t st;

  bmaff_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .st         (st),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  bmaff_dp #(
    .MAX_BITS  (MAX_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_bit_index    (in_bit_index),
    .cfg_we          (cfg_we),
    .cfg_active_bits (cfg_active_bits),
    .cmd             (cmd),
    .st              (st),
    .out_ok          (out_ok),
    .out_found_index (out_found_index),
    .out_range_error (out_range_error)
  );

  // A result only follows a cycle of work.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without preceding busy cycle");

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe))
    else $error("request transfer not followed by busy");

  // A range error never reports success or a claimed index.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_range_error) |-> (!out_ok && out_found_index == 10'd0))
    else $error("range error with ok or found index set");

endmodule
